/* rtl/core/sbls_pkg.sv */
// Shared constants for the spectrum band level smoother.
// Used by the core, its port checkers and the testbench top; depends on nothing else.
`default_nettype none
package sbls_pkg;

    // default number of bands per frame
    localparam int BAND_COUNT_DEF = 16;

    // field widths
    localparam int MAG_W   = 16;
    localparam int INDEX_W = 6;
    localparam int LEVEL_W = 8;
    localparam int OUT_TDATA_W = ((INDEX_W + LEVEL_W + 7) / 8) * 8;

    // scaling and smoothing constants
    localparam int LEVEL_FULL   = 255;
    localparam int KEEP_WEIGHT  = 9;
    localparam int TOTAL_WEIGHT = 10;

    // serial divider: 8 quotient bits, dividend up to 65535 * 255
    localparam int QUOT_W = LEVEL_W;
    localparam int DIV_W  = MAG_W + QUOT_W;

endpackage
`default_nettype wire

/* rtl/core/spectrum_band_level_smoother.sv */
// Spectrum band level smoother: frame buffer, peak tracker, serial divider, level store.
// Depends on sbls_pkg.
//
// The block takes BAND_COUNT band magnitudes per frame, one per request, and stores them
// while tracking the frame peak. After the last band it emits one request per band, in
// band order: the band is scaled to floor(mag*255/peak) (0 for a zero peak), then
// smoothed as floor((9*old+scaled)/10) into a per-band level store cleared at reset.
// Both divisions run on one restoring divider that makes one quotient bit per cycle;
// each band steps through read, load, 8 quotient bits, load, 8 quotient bits and
// output, and the output step waits while a stalled result is held. Input is not
// taken during emission.
`default_nettype none
module spectrum_band_level_smoother #(
    parameter int BAND_COUNT = sbls_pkg::BAND_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input stream: tdata = band_magnitude[15:0]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sbls_pkg::MAG_W-1:0]     s_tdata,
    // output stream: tdata = band_index[5:0], led_level[13:6], zero [15:14]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sbls_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // frame_last
    output logic                                m_tlast
);

    localparam int IDX_W = $clog2(BAND_COUNT);
    localparam logic [IDX_W-1:0] LAST_BAND = IDX_W'(BAND_COUNT - 1);
    localparam int DIV_W  = sbls_pkg::DIV_W;
    localparam int QUOT_W = sbls_pkg::QUOT_W;
    localparam int MAG_W  = sbls_pkg::MAG_W;
    localparam int LEVEL_W = sbls_pkg::LEVEL_W;
    localparam int PAD_W  = sbls_pkg::OUT_TDATA_W - sbls_pkg::INDEX_W - LEVEL_W;
    // divisor of the smoothing step, aligned to the top quotient bit
    localparam logic [DIV_W-1:0] TEN_ALIGNED =
        DIV_W'(sbls_pkg::TOTAL_WEIGHT) << (QUOT_W - 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_RD,
        S_LD1,
        S_DIV1,
        S_LD2,
        S_DIV2,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          band_reg;
    logic [MAG_W-1:0]          peak_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [DIV_W-1:0]          dvs_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic [2:0]                step_reg;
    logic                      m_tvalid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic [LEVEL_W-1:0]        out_level_reg;
    logic                      out_last_reg;

    // memories
    logic [MAG_W-1:0]          sample_mem [BAND_COUNT];
    logic [LEVEL_W-1:0]        level_mem  [BAND_COUNT];
    logic [MAG_W-1:0]          sample_rd_reg;
    logic [LEVEL_W-1:0]        level_rd_reg;
    logic                      level_vld_rd_reg;
    logic [BAND_COUNT-1:0]     level_vld_reg;

    logic                      in_accept;
    logic                      out_load;
    logic                      rem_ge;
    logic [DIV_W-1:0]          rem_next;
    logic [QUOT_W-1:0]         quot_next;
    logic [LEVEL_W-1:0]        old_level;
    logic [LEVEL_W-1:0]        scaled;
    logic [DIV_W-1:0]          smooth_num;
    logic [DIV_W-1:0]          scale_num;

    assign s_tready  = (state_reg == S_FILL);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {PAD_W'(0), out_level_reg, sbls_pkg::INDEX_W'(out_index_reg)};

    // one restoring step: one quotient bit per cycle
    always_comb
    begin
        rem_ge    = (rem_reg >= dvs_reg);
        rem_next  = rem_ge ? (rem_reg - dvs_reg) : rem_reg;
        quot_next = {quot_reg[QUOT_W-2:0], rem_ge};
    end

    // dividends: mag*255 and 9*old + scaled
    always_comb
    begin
        old_level  = level_vld_rd_reg ? level_rd_reg : '0;
        scaled     = (peak_reg == '0) ? '0 : quot_reg;
        scale_num  = {sample_rd_reg, QUOT_W'(0)} - DIV_W'(sample_rd_reg);
        smooth_num = DIV_W'({old_level, 3'b000}) + DIV_W'(old_level) + DIV_W'(scaled);
    end

    // sample buffer: written during fill, read once per band
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_mem[band_reg] <= s_tdata;
        end
        if (state_reg == S_RD)
        begin
            sample_rd_reg <= sample_mem[band_reg];
        end
    end

    // level store: written at output, read at start of each band
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_mem[band_reg] <= quot_next;
        end
        if (state_reg == S_RD)
        begin
            level_rd_reg <= level_mem[band_reg];
        end
    end

    // level valid bits stand for the cleared store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_vld_reg    <= '0;
            level_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                level_vld_reg[band_reg] <= 1'b1;
            end
            if (state_reg == S_RD)
            begin
                level_vld_rd_reg <= level_vld_reg[band_reg];
            end
        end
    end

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            band_reg      <= '0;
            peak_reg      <= '0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            out_index_reg <= '0;
            out_level_reg <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            quot_reg      <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_FILL:
                begin
                    if (in_accept)
                    begin
                        if (s_tdata > peak_reg)
                        begin
                            peak_reg <= s_tdata;
                        end
                        if (band_reg == LAST_BAND)
                        begin
                            band_reg  <= '0;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            band_reg <= band_reg + 1'b1;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LD1;
                end
                S_LD1:
                begin
                    rem_reg   <= scale_num;
                    dvs_reg   <= DIV_W'(peak_reg) << (QUOT_W - 1);
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    rem_reg  <= rem_next;
                    dvs_reg  <= dvs_reg >> 1;
                    quot_reg <= quot_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'(QUOT_W - 1))
                    begin
                        state_reg <= S_LD2;
                    end
                end
                S_LD2:
                begin
                    rem_reg   <= smooth_num;
                    dvs_reg   <= TEN_ALIGNED;
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    // last step is folded into the output load
                    if (step_reg == 3'(QUOT_W - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rem_reg  <= rem_next;
                        dvs_reg  <= dvs_reg >> 1;
                        quot_reg <= quot_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_index_reg <= band_reg;
                        out_level_reg <= quot_next;
                        out_last_reg  <= (band_reg == LAST_BAND);
                        if (band_reg == LAST_BAND)
                        begin
                            band_reg  <= '0;
                            peak_reg  <= '0;
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            band_reg  <= band_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sbls_checker.sv */
// Port-level checker for the spectrum band level smoother, and its bind.
// Depends on sbls_pkg and spectrum_band_level_smoother.
`default_nettype none
module sbls_checker #(
    parameter int BAND_COUNT = sbls_pkg::BAND_COUNT_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [sbls_pkg::MAG_W-1:0]        s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [sbls_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic                              m_tlast
);

    localparam int IW = sbls_pkg::INDEX_W;
    localparam int TOP = sbls_pkg::INDEX_W + sbls_pkg::LEVEL_W;

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result request changed while stalled");

    // band index stays inside the frame
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[IW-1:0] <= IW'(BAND_COUNT - 1)))
        else $error("band index out of range");

    // last flag marks the final band only
    a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[IW-1:0] == IW'(BAND_COUNT - 1))))
        else $error("frame_last does not match final band");

    // no input is taken while a frame is still being emitted
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during frame emission");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[sbls_pkg::OUT_TDATA_W-1:TOP] == '0))
        else $error("nonzero pad bits in result");

endmodule

bind spectrum_band_level_smoother sbls_checker #(
    .BAND_COUNT(BAND_COUNT)
) u_sbls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

/* bench/band_level_check.sv */
// Port-level checker for the spectrum band level smoother: rebuilds each frame's
// smoothed band levels from the accepted input requests and compares the output stream.
// Depends on sbls_pkg; instantiated by the testbench top beside the block.
module band_level_check #(
    parameter int BAND_COUNT = sbls_pkg::BAND_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [sbls_pkg::MAG_W-1:0]          s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sbls_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_W = sbls_pkg::INDEX_W;
    localparam int LEVEL_W = sbls_pkg::LEVEL_W;
    localparam int PAD_LO  = INDEX_W + LEVEL_W;

    typedef struct packed {
        logic [INDEX_W-1:0] band_index;
        logic [LEVEL_W-1:0] led_level;
        logic               frame_last;
    } band_result_t;

    // levels still owed by the block, oldest first
    band_result_t owed_levels[$];

    // own copy of the frame buffer, peak tracker and level store
    logic [sbls_pkg::MAG_W-1:0] frame_mags [BAND_COUNT];
    logic [sbls_pkg::MAG_W-1:0] frame_peak_mag;
    logic [LEVEL_W-1:0]         band_levels [BAND_COUNT];
    int                         bands_taken;

    // floor(mag * 255 / peak), zero for an all-zero frame
    function automatic int unsigned scale_to_peak(int unsigned mag, int unsigned peak);
        if (peak == 0)
            return 0;
        return (mag * sbls_pkg::LEVEL_FULL) / peak;
    endfunction

    // frame complete: smooth every band and queue its level
    task automatic smooth_frame_levels();
        band_result_t res;
        int unsigned  lvl;
        for (int b = 0; b < BAND_COUNT; b++)
        begin
            lvl = (sbls_pkg::KEEP_WEIGHT * int'(band_levels[b])
                   + scale_to_peak(frame_mags[b], frame_peak_mag)) / sbls_pkg::TOTAL_WEIGHT;
            if (lvl > sbls_pkg::LEVEL_FULL)
                lvl = sbls_pkg::LEVEL_FULL;
            band_levels[b]  = LEVEL_W'(lvl);
            res.band_index  = INDEX_W'(b);
            res.led_level   = LEVEL_W'(lvl);
            res.frame_last  = (b == BAND_COUNT - 1);
            owed_levels.push_back(res);
        end
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        band_result_t want;
        if (!rst_n)
        begin
            owed_levels.delete();
            frame_peak_mag = '0;
            bands_taken    = 0;
            for (int b = 0; b < BAND_COUNT; b++)
                band_levels[b] = '0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // output request: compare with the oldest owed level
            if (m_tvalid && m_tready)
            begin
                if (owed_levels.size() == 0)
                begin
                    $error("unexpected result: band_index %0d, led_level %0d, frame_last %0d",
                           m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: LEVEL_W], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = owed_levels.pop_front();
                    compare_field("band_index", 16'(want.band_index), 16'(m_tdata[INDEX_W-1:0]));
                    compare_field("led_level", 16'(want.led_level),
                                  16'(m_tdata[INDEX_W +: LEVEL_W]));
                    compare_field("frame_last", 16'(want.frame_last), 16'(m_tlast));
                    compare_field("tdata_pad", 16'd0,
                                  16'(m_tdata[sbls_pkg::OUT_TDATA_W-1:PAD_LO]));
                end
            end

            // input request: store the band, track the peak
            if (s_tvalid && s_tready)
            begin
                frame_mags[bands_taken] = s_tdata;
                if (s_tdata > frame_peak_mag)
                    frame_peak_mag = s_tdata;
                bands_taken++;
                if (bands_taken == BAND_COUNT)
                begin
                    smooth_frame_levels();
                    bands_taken    = 0;
                    frame_peak_mag = '0;
                end
            end
            pending = owed_levels.size();
        end
    end

endmodule

/* bench/testbench.sv */
// Testbench top for the spectrum band level smoother: clock, reset, band stimulus
// and output back-pressure. Depends on sbls_pkg, the block and band_level_check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANDS          = sbls_pkg::BAND_COUNT_DEF;
    localparam int MAG_W          = sbls_pkg::MAG_W;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_FRAMES  = 18;
    localparam int MAX_IDLE       = 11;
    localparam int HOLD_AT_RESULT = 37;
    localparam int HOLD_CYCLES    = 400;
    localparam int PAUSE_FRAME    = 6;
    localparam int DRAIN_CYCLES   = 60;
    localparam longint TIMEOUT_NS = 200_000 * 2 * HALF_PERIOD;

    typedef enum int {
        FRAME_ZERO,
        FRAME_FULL,
        FRAME_LOW,
        FRAME_SPIKE,
        FRAME_FLAT
    } frame_kind_t;

    // extremes and bit patterns for the first frame
    localparam logic [MAG_W-1:0] DIRECTED_MAGS [16] = '{
        16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF,
        16'h00FF, 16'hFF00, 16'h0002, 16'hFFFF, 16'h0064, 16'h3039, 16'h0F0F, 16'h0000
    };

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [MAG_W-1:0]                 s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sbls_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tlast;
    int                               fail_total;
    int                               results_pending;

    spectrum_band_level_smoother #(
        .BAND_COUNT(BANDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    band_level_check #(
        .BAND_COUNT(BANDS)
    ) level_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_total),
        .pending    (results_pending)
    );

    // 12 ns clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #(TIMEOUT_NS);
        $display("spectrum_band_level_smoother: mismatch");
        $finish;
    end

    // magnitude of one band for a given frame shape
    function automatic logic [MAG_W-1:0] band_value(frame_kind_t kind, int band, int spike_band,
                                                     logic [MAG_W-1:0] flat_mag);
        case (kind)
            FRAME_ZERO:  return '0;
            FRAME_LOW:   return MAG_W'($urandom_range(0, 15));
            FRAME_SPIKE: return (band == spike_band) ? MAG_W'($urandom)
                                                     : MAG_W'($urandom_range(0, 255));
            FRAME_FLAT:  return flat_mag;
            default:     return MAG_W'($urandom);
        endcase
    endfunction

    // one input request, after a random gap unless gaps are off
    task automatic offer_band(input logic [MAG_W-1:0] mag, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // output back-pressure, with one long hold mid-emission
    initial
    begin
        int stall;
        int taken;
        bit no_stalls;
        m_tready  = 1'b0;
        taken     = 0;
        no_stalls = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % BANDS == 0)
                no_stalls = ($urandom_range(0, 3) == 0);
            stall = no_stalls ? 0 : $urandom_range(0, MAX_IDLE);
            if (taken == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            taken++;
            @(negedge clk);
        end
    end

    // band stimulus and verdict
    initial
    begin
        frame_kind_t      kind;
        bit               no_gaps;
        int               spike_band;
        logic [MAG_W-1:0] flat_mag;
        int               tail_len;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frame: field extremes and bit patterns
        for (int b = 0; b < BANDS; b++)
            offer_band(DIRECTED_MAGS[b % 16], 1'b0);

        // random frames, the first one all zero
        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            case ($urandom_range(0, 9))
                0:       kind = FRAME_ZERO;
                1, 2:    kind = FRAME_LOW;
                3, 4:    kind = FRAME_SPIKE;
                5:       kind = FRAME_FLAT;
                default: kind = FRAME_FULL;
            endcase
            if (f == 0)
                kind = FRAME_ZERO;
            no_gaps    = ($urandom_range(0, 3) == 0);
            spike_band = $urandom_range(0, BANDS - 1);
            flat_mag   = MAG_W'($urandom);
            for (int b = 0; b < BANDS; b++)
                offer_band(band_value(kind, b, spike_band, flat_mag), no_gaps);

            // let the block drain completely once
            if (f == PAUSE_FRAME)
            begin
                s_tvalid <= 1'b0;
                wait (results_pending == 0);
                @(negedge clk);
            end
        end

        // partial frame that produces no result
        tail_len = $urandom_range(1, BANDS - 1);
        for (int b = 0; b < tail_len; b++)
            offer_band(MAG_W'($urandom), 1'b0);
        s_tvalid <= 1'b0;

        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_total == 0 && results_pending == 0)
            $display("spectrum_band_level_smoother: match");
        else
            $display("spectrum_band_level_smoother: mismatch");
        $finish;
    end

endmodule
